// ===== design/jsd_pkg.sv =====
// ----------------------------------------------------------------------------
// jsd_pkg: shared types and constants of the deadline scheduler
// Field widths, the default job store depth and the scheduler state type.
// ----------------------------------------------------------------------------
package jsd_pkg;

    localparam int MAX_JOBS_DEF = 256;

    localparam int DL_W    = 16;
    localparam int PR_W    = 16;
    localparam int DONE_W  = 9;
    localparam int TOTAL_W = 24;

    // Input word: deadline, then profit.
    localparam int S_DATA_W = 32;
    // Output word: jobs_done, total_profit, set_overflow, zero padded.
    localparam int M_DATA_W = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MARK,
        ST_SLOT_RD,
        ST_SLOT_CHK,
        ST_RESULT
    } sched_state_t;

    typedef struct packed {
        logic set_done;
        logic busy;
    } sched_status_t;

endpackage

// ===== design/jsd_ram.sv =====
// ----------------------------------------------------------------------------
// jsd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module jsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/jsd_queue.sv =====
// ----------------------------------------------------------------------------
// jsd_queue: two-entry command queue
// Carries closed job sets from the loader to the scheduler.
// ----------------------------------------------------------------------------
module jsd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             valid
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign dout    = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

// ===== design/jsd_front.sv =====
// ----------------------------------------------------------------------------
// jsd_front: job loader
// Writes incoming jobs into the job store, counts them, flags overflow and
// hands each closed set to the scheduler through the command queue.
// ----------------------------------------------------------------------------
module jsd_front #(
    parameter int MAX_JOBS = jsd_pkg::MAX_JOBS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [jsd_pkg::S_DATA_W-1:0]           s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   st_we,
    output logic [$clog2(MAX_JOBS)-1:0]            st_waddr,
    output logic [jsd_pkg::DL_W+jsd_pkg::PR_W-1:0] st_wdata,
    output logic                                   q_push,
    output logic [$clog2(MAX_JOBS+1):0]            q_din,
    input  logic                                   q_full,
    input  jsd_pkg::sched_status_t                 status
);

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          pend_reg, pend_next;
    logic          accept, room;

    // The store is shared with the scheduler, so a new set waits for the last.
    assign s_axis_tready = !pend_reg && !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign room          = (cnt_reg < CW'(MAX_JOBS));

    assign st_we    = accept && room;
    assign st_waddr = cnt_reg[IW-1:0];
    assign st_wdata = s_axis_tdata[jsd_pkg::DL_W+jsd_pkg::PR_W-1:0];

    always_comb begin
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        pend_next = pend_reg;
        if (status.set_done) begin
            pend_next = 1'b0;
        end
        if (accept) begin
            if (room) begin
                cnt_next = cnt_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        q_push = accept && s_axis_tlast;
        q_din  = {ovf_next, cnt_next};
        if (q_push) begin
            cnt_next  = '0;
            ovf_next  = 1'b0;
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== design/jsd_back.sv =====
// ----------------------------------------------------------------------------
// jsd_back: greedy scheduler
// Clears the slot and used maps, then repeatedly picks the most profitable
// unused job and scans down from its bound for a free slot.
// ----------------------------------------------------------------------------
module jsd_back #(
    parameter int MAX_JOBS = jsd_pkg::MAX_JOBS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid,
    input  logic [$clog2(MAX_JOBS+1):0]            q_dout,
    output logic                                   q_pop,
    output logic [$clog2(MAX_JOBS)-1:0]            st_raddr,
    input  logic [jsd_pkg::DL_W+jsd_pkg::PR_W-1:0] st_rdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [jsd_pkg::M_DATA_W-1:0]           m_axis_tdata,
    output jsd_pkg::sched_status_t                 status
);

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int DL_W = jsd_pkg::DL_W;
    localparam int PR_W = jsd_pkg::PR_W;

    jsd_pkg::sched_state_t state_reg, state_next;

    logic [CW-1:0]               n_reg;
    logic                        ovf_reg;
    logic [IW-1:0]               k_reg;
    logic [IW-1:0]               best_idx_reg;
    logic [DL_W-1:0]             best_dl_reg;
    logic [PR_W-1:0]             best_pr_reg;
    logic                        found_reg;
    logic [IW-1:0]               s_reg;
    logic [jsd_pkg::DONE_W-1:0]  done_reg;
    logic [jsd_pkg::TOTAL_W-1:0] total_reg;
    logic                        m_valid_reg;
    logic [jsd_pkg::M_DATA_W-1:0] m_data_reg;

    logic            used_we, used_wdata, used_rdata;
    logic [IW-1:0]   used_waddr;
    logic            slot_we, slot_wdata, slot_rdata;
    logic [IW-1:0]   slot_waddr;

    logic            k_last, better, found_next, out_free, load_out;
    logic [DL_W-1:0] cur_dl, dl_m1, n_m1;
    logic [PR_W-1:0] cur_pr;
    logic [IW-1:0]   top;

    assign cur_dl = st_rdata[DL_W-1:0];
    assign cur_pr = st_rdata[DL_W+PR_W-1:DL_W];
    assign k_last = (k_reg == IW'(n_reg - CW'(1)));
    assign better = !used_rdata && (!found_reg || (cur_pr > best_pr_reg));
    assign found_next = found_reg || better;
    assign out_free = !m_valid_reg || m_axis_tready;

    // Latest usable slot: min(deadline - 1, n - 1).
    assign dl_m1 = best_dl_reg - DL_W'(1);
    assign n_m1  = DL_W'(n_reg - CW'(1));
    assign top   = (dl_m1 < n_m1) ? dl_m1[IW-1:0] : n_m1[IW-1:0];

    jsd_ram #(.WIDTH(1), .DEPTH(MAX_JOBS)) u_used (
        .aclk  (aclk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (k_reg),
        .rdata (used_rdata)
    );

    jsd_ram #(.WIDTH(1), .DEPTH(MAX_JOBS)) u_slot (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (s_reg),
        .rdata (slot_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jsd_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = (q_dout[CW-1:0] == '0) ? jsd_pkg::ST_RESULT
                                                        : jsd_pkg::ST_CLEAR;
                end
            end
            jsd_pkg::ST_CLEAR: begin
                if (k_last) begin
                    state_next = jsd_pkg::ST_SCAN_RD;
                end
            end
            jsd_pkg::ST_SCAN_RD: state_next = jsd_pkg::ST_SCAN_CHK;
            jsd_pkg::ST_SCAN_CHK: begin
                if (k_last) begin
                    state_next = found_next ? jsd_pkg::ST_MARK : jsd_pkg::ST_RESULT;
                end else begin
                    state_next = jsd_pkg::ST_SCAN_RD;
                end
            end
            jsd_pkg::ST_MARK: begin
                state_next = (best_dl_reg == '0) ? jsd_pkg::ST_SCAN_RD
                                                 : jsd_pkg::ST_SLOT_RD;
            end
            jsd_pkg::ST_SLOT_RD: state_next = jsd_pkg::ST_SLOT_CHK;
            jsd_pkg::ST_SLOT_CHK: begin
                if (!slot_rdata || (s_reg == '0)) begin
                    state_next = jsd_pkg::ST_SCAN_RD;
                end else begin
                    state_next = jsd_pkg::ST_SLOT_RD;
                end
            end
            jsd_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = jsd_pkg::ST_IDLE;
                end
            end
            default: state_next = jsd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        used_we    = 1'b0;
        used_waddr = k_reg;
        used_wdata = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = k_reg;
        slot_wdata = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            jsd_pkg::ST_IDLE: q_pop = q_valid;
            jsd_pkg::ST_CLEAR: begin
                used_we = 1'b1;
                slot_we = 1'b1;
            end
            jsd_pkg::ST_MARK: begin
                used_we    = 1'b1;
                used_waddr = best_idx_reg;
                used_wdata = 1'b1;
            end
            jsd_pkg::ST_SLOT_CHK: begin
                slot_we    = !slot_rdata;
                slot_waddr = s_reg;
                slot_wdata = 1'b1;
            end
            jsd_pkg::ST_RESULT: load_out = out_free;
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign st_raddr        = k_reg;
    assign status.set_done = load_out;
    assign status.busy     = (state_reg != jsd_pkg::ST_IDLE);
    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= jsd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {{(jsd_pkg::M_DATA_W - jsd_pkg::DONE_W - jsd_pkg::TOTAL_W - 1){1'b0}},
                           ovf_reg, total_reg, done_reg};
        end
        case (state_reg)
            jsd_pkg::ST_IDLE: begin
                n_reg     <= q_dout[CW-1:0];
                ovf_reg   <= q_dout[CW];
                k_reg     <= '0;
                found_reg <= 1'b0;
                done_reg  <= '0;
                total_reg <= '0;
            end
            jsd_pkg::ST_CLEAR: begin
                k_reg <= k_last ? '0 : k_reg + IW'(1);
            end
            jsd_pkg::ST_SCAN_CHK: begin
                if (better) begin
                    best_idx_reg <= k_reg;
                    best_dl_reg  <= cur_dl;
                    best_pr_reg  <= cur_pr;
                end
                found_reg <= found_next;
                k_reg     <= k_last ? '0 : k_reg + IW'(1);
            end
            jsd_pkg::ST_MARK: begin
                found_reg <= 1'b0;
                s_reg     <= top;
            end
            jsd_pkg::ST_SLOT_CHK: begin
                if (!slot_rdata) begin
                    done_reg  <= done_reg + jsd_pkg::DONE_W'(1);
                    total_reg <= total_reg + jsd_pkg::TOTAL_W'(best_pr_reg);
                end else if (s_reg != '0) begin
                    s_reg <= s_reg - IW'(1);
                end
            end
            default: begin
                s_reg <= s_reg;
            end
        endcase
    end

endmodule

// ===== design/job_sequencing_deadline_scheduler.sv =====
// ----------------------------------------------------------------------------
// job_sequencing_deadline_scheduler: greedy job sequencing with deadlines
// Loads a set of unit-time jobs and reports how many fit before their
// deadlines, taken by descending profit, and their total profit.
//
// Channel  Dir  Width  Content (low bit first)
// s_axis   in   32+1   tdata: deadline[15:0], job_profit[31:16]; tlast: last_job
// m_axis   out  40     tdata: jobs_done[8:0], total_profit[32:9],
//                      set_overflow[33], zero[39:34]
//
// Loading accepts one word per cycle while s_axis_tready is high. Scheduling
// a set takes the set from the queue, clears the slot and used maps, then
// scans the job store for the most profitable unused job once for each job
// plus one closing scan, marks that job used and probes slots down from its
// bound; the single read port of the job store makes each scan sequential.
// Reset is synchronous and active low. Input stalls from the closing word
// until the result is in the output register; a result still waiting there
// holds back the next set's result, and with it the input.
// ----------------------------------------------------------------------------
module job_sequencing_deadline_scheduler #(
    parameter int MAX_JOBS = jsd_pkg::MAX_JOBS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // deadline[15:0], job_profit[31:16]
    input  logic [jsd_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // jobs_done[8:0], total_profit[32:9], set_overflow[33], zero[39:34]
    output logic [jsd_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int SW = jsd_pkg::DL_W + jsd_pkg::PR_W;

    logic                  st_we;
    logic [IW-1:0]         st_waddr, st_raddr;
    logic [SW-1:0]         st_wdata, st_rdata;
    logic                  q_push, q_full, q_pop, q_valid;
    logic [CW:0]           q_din, q_dout;
    jsd_pkg::sched_status_t status;

    jsd_front #(.MAX_JOBS(MAX_JOBS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .st_we         (st_we),
        .st_waddr      (st_waddr),
        .st_wdata      (st_wdata),
        .q_push        (q_push),
        .q_din         (q_din),
        .q_full        (q_full),
        .status        (status)
    );

    jsd_ram #(.WIDTH(SW), .DEPTH(MAX_JOBS)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    jsd_queue #(.WIDTH(CW + 1)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .valid   (q_valid)
    );

    jsd_back #(.MAX_JOBS(MAX_JOBS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_dout        (q_dout),
        .q_pop         (q_pop),
        .st_raddr      (st_raddr),
        .st_rdata      (st_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .status        (status)
    );

`ifndef SYNTHESIS
    // The job store must not be written while a set is being scheduled.
    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> !s_axis_tready)
        else $error("input accepted while scheduler busy");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("set queued into a full queue");

    a_result_from_set: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(status.set_done))
        else $error("result word appeared without a finished set");
`endif

endmodule
